@@ src/rsi_pkg.sv @@
package rsi_pkg;

    // Field widths.
    localparam int unsigned CoordW = 32;
    localparam int unsigned DirW   = 16;
    localparam int unsigned RadW   = 31;
    localparam int unsigned DistW  = 31;

    // Internal widths of the datapath.
    localparam int unsigned DiffW  = 33;  // origin minus center
    localparam int unsigned HW     = 35;  // half-linear term in Q16.16
    localparam int unsigned DiscW  = 70;  // discriminant in Q32.32
    localparam int unsigned RootW  = 35;  // square root in Q16.16

    // One square-root cell per result bit.
    localparam int unsigned SqCells = RootW;

    // Near limit 0.001 in Q16.16.
    localparam logic signed [HW+1:0] NearLimit = 37'sd65;
    localparam logic [DistW-1:0]     DistMax   = '1;

    // Register indexes.
    localparam logic [1:0] RegCx  = 2'd0;
    localparam logic [1:0] RegCy  = 2'd1;
    localparam logic [1:0] RegCz  = 2'd2;
    localparam logic [1:0] RegRad = 2'd3;

    typedef struct packed {
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] cz;
        logic [RadW-1:0]          rad;
    } t_sph_cfg;

    // Data handed from cell to cell.
    typedef struct packed {
        logic                 valid;
        logic                 neg;
        logic signed [HW-1:0] h16;
        logic [DiscW-1:0]     rem;
        logic [RootW-1:0]     root;
    } t_sq;

endpackage

@@ src/rsi_front.sv @@
module rsi_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [143:0]                          i_data,
    input  rsi_pkg::t_sph_cfg                     i_sph,
    output rsi_pkg::t_sq                          o_sq
);
    import rsi_pkg::*;

    logic [4:0] r_v;

    // Stage 1: offsets from the center.
    logic signed [DiffW-1:0] r_dx, r_dy, r_dz;
    logic signed [DirW-1:0]  r_ux, r_uy, r_uz;
    // Stage 2: products.
    logic signed [48:0]      r_px, r_py, r_pz;
    logic [64:0]             r_sx, r_sy, r_sz;
    logic [61:0]             r_rr2, r_rr3, r_rr4;
    // Stage 3: sums.
    logic signed [HW-1:0]    r_h3, r_h4;
    logic [66:0]             r_sum3, r_sum4;
    // Stage 4: square of the half-linear term.
    logic [68:0]             r_hh;
    // Stage 5: discriminant handed to the first cell.
    logic                    r_neg;
    logic signed [HW-1:0]    r_h5;
    logic [DiscW-1:0]        r_rem;

    logic signed [65:0] w_sx, w_sy, w_sz;
    logic signed [49:0] w_h;
    logic signed [69:0] w_hh;
    logic [DiscW-1:0]   w_lhs;

    assign w_sx  = r_dx * r_dx;
    assign w_sy  = r_dy * r_dy;
    assign w_sz  = r_dz * r_dz;
    assign w_h   = 50'(r_px) + 50'(r_py) + 50'(r_pz);
    assign w_hh  = r_h3 * r_h3;
    assign w_lhs = 70'(r_hh) + 70'(r_rr4);

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= DiffW'($signed(i_data[31:0]))  - DiffW'(i_sph.cx);
            r_dy <= DiffW'($signed(i_data[63:32])) - DiffW'(i_sph.cy);
            r_dz <= DiffW'($signed(i_data[95:64])) - DiffW'(i_sph.cz);
            r_ux <= $signed(i_data[111:96]);
            r_uy <= $signed(i_data[127:112]);
            r_uz <= $signed(i_data[143:128]);

            r_px  <= r_dx * r_ux;
            r_py  <= r_dy * r_uy;
            r_pz  <= r_dz * r_uz;
            r_sx  <= w_sx[64:0];
            r_sy  <= w_sy[64:0];
            r_sz  <= w_sz[64:0];
            r_rr2 <= 62'(i_sph.rad) * 62'(i_sph.rad);

            // Arithmetic shift floors toward minus infinity.
            r_h3   <= w_h[49:15];
            r_sum3 <= 67'(r_sx) + 67'(r_sy) + 67'(r_sz);
            r_rr3  <= r_rr2;

            r_h4   <= r_h3;
            r_sum4 <= r_sum3;
            r_rr4  <= r_rr3;
            r_hh   <= w_hh[68:0];

            r_h5  <= r_h4;
            r_neg <= w_lhs < 70'(r_sum4);
            r_rem <= w_lhs - 70'(r_sum4);
        end
    end

    assign o_sq = '{valid: r_v[4], neg: r_neg, h16: r_h5, rem: r_rem, root: '0};

endmodule

@@ src/rsi_sqrt_cell.sv @@
module rsi_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [5:0]    i_idx,
    input  rsi_pkg::t_sq  i_d,
    output rsi_pkg::t_sq  o_d
);
    import rsi_pkg::*;

    logic [DiscW:0] w_trial;
    logic           w_take;

    // Growth of the square when bit idx is set: 2*root*2^idx + 4^idx.
    assign w_trial = ((DiscW+1)'(i_d.root) << (7'(i_idx) + 7'd1))
                   + ((DiscW+1)'(1) << {i_idx, 1'b0});
    assign w_take  = {1'b0, i_d.rem} >= w_trial;

    // Valid bit is cleared by reset; the data follows it whenever the chain moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_d.valid <= 1'b0;
        end else if (i_en) begin
            o_d.valid <= i_d.valid;
            o_d.neg   <= i_d.neg;
            o_d.h16   <= i_d.h16;
            if (w_take) begin
                o_d.rem  <= i_d.rem - w_trial[DiscW-1:0];
                o_d.root <= i_d.root | (RootW'(1) << i_idx);
            end else begin
                o_d.rem  <= i_d.rem;
                o_d.root <= i_d.root;
            end
        end
    end

endmodule

@@ src/ray_sphere_intersect.sv @@
// Pipeline: five setup stages, one square-root cell per root bit and one
// output stage. Throughput: one ray per cycle; the whole pipeline holds while
// a result waits at the output. Reset is synchronous, active low: it clears
// all valid bits, sets the center to zero and the radius to 1.0.
module ray_sphere_intersect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [143:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // hit, distance
    output logic [31:0] o_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rsi_pkg::*;

    t_sph_cfg r_sph;
    logic     w_en;
    t_sq      w_chain [SqCells+1];

    logic                   r_valid;
    logic                   r_hit;
    logic [DistW-1:0]       r_dist;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sph.cx  <= '0;
            r_sph.cy  <= '0;
            r_sph.cz  <= '0;
            r_sph.rad <= RadW'(65536);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                RegCx:   r_sph.cx  <= pwdata;
                RegCy:   r_sph.cy  <= pwdata;
                RegCz:   r_sph.cz  <= pwdata;
                RegRad:  r_sph.rad <= pwdata[RadW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegCx:   prdata = r_sph.cx;
            RegCy:   prdata = r_sph.cy;
            RegCz:   prdata = r_sph.cz;
            RegRad:  prdata = {1'b0, r_sph.rad};
            default: prdata = '0;
        endcase
    end

    // The pipeline moves whenever the output stage is free.
    assign w_en       = !r_valid || i_m_tready;
    assign o_s_tready = w_en;

    rsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_sph   (r_sph),
        .o_sq    (w_chain[0])
    );

    // Square-root cells, most significant root bit first.
    for (genvar g = 0; g < SqCells; g++) begin : g_cell
        rsi_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (6'(SqCells - 1 - g)),
            .i_d     (w_chain[g]),
            .o_d     (w_chain[g+1])
        );
    end

    // Root selection and saturation.
    logic signed [HW+1:0] w_t1, w_t2, w_t;
    logic                 w_hit;
    t_sq                  w_last;

    assign w_last = w_chain[SqCells];
    assign w_t1   = -(HW+2)'(w_last.h16) - (HW+2)'(w_last.root);
    assign w_t2   = -(HW+2)'(w_last.h16) + (HW+2)'(w_last.root);
    assign w_hit  = !w_last.neg && (w_t1 > NearLimit || w_t2 > NearLimit);
    assign w_t    = (w_t1 > NearLimit) ? w_t1 : w_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= w_hit;
            if (!w_hit) begin
                r_dist <= '0;
            end else if (w_t > (HW+2)'(DistMax)) begin
                r_dist <= DistMax;
            end else begin
                r_dist <= w_t[DistW-1:0];
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_dist, r_hit};

    // A miss always carries a zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[31:1] == '0))
        else $error("miss with nonzero distance");

    // A hit lies beyond the near limit.
    a_hit_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[31:1] > 31'd65))
        else $error("hit at or inside near limit");

    // A result held at the output keeps its data and the input stays stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

@@ tb/ray_sphere_checker.sv @@
module ray_sphere_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [143:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [31:0]  i_m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results_seen,
    output int           o_hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import rsi_pkg::*;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic             hit;
    } t_hit;

    logic signed [CoordW-1:0] sph_cx, sph_cy, sph_cz;
    logic [RadW-1:0]          sph_rad;
    t_hit                     expected_hits[$];

    // Floor integer square root of a Q32.32 value, giving Q16.16.
    function automatic longint isqrt_q32(logic [127:0] v);
        logic [127:0] root;
        logic [127:0] cand;
        root = '0;
        for (int b = 40; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= v) root = cand;
        end
        return longint'(root);
    endfunction

    function automatic logic [127:0] square_mag(longint v);
        logic [127:0] m;
        m = (v < 0) ? 128'(-v) : 128'(v);
        return m * m;
    endfunction

    // Nearest intersection of one ray with the current sphere.
    function automatic t_hit trace_ray(logic [143:0] ray);
        longint       dx, dy, dz, h, h16, s, t1, t2, t;
        logic [127:0] lhs, sum;
        t_hit         r;
        dx = longint'($signed(ray[31:0])) - longint'(sph_cx);
        dy = longint'($signed(ray[63:32])) - longint'(sph_cy);
        dz = longint'($signed(ray[95:64])) - longint'(sph_cz);
        h = dx * longint'($signed(ray[111:96])) + dy * longint'($signed(ray[127:112]))
            + dz * longint'($signed(ray[143:128]));
        // Arithmetic shift rounds toward minus infinity.
        h16 = h >>> 15;
        lhs = square_mag(h16) + 128'(sph_rad) * 128'(sph_rad);
        sum = square_mag(dx) + square_mag(dy) + square_mag(dz);
        r = '0;
        if (lhs >= sum) begin
            s  = isqrt_q32(lhs - sum);
            t1 = -h16 - s;
            t2 = -h16 + s;
            t  = 0;
            if (t1 > 65) begin
                t = t1;
                r.hit = 1'b1;
            end else if (t2 > 65) begin
                t = t2;
                r.hit = 1'b1;
            end
            if (r.hit) r.distance = (t > 64'sh7FFF_FFFF) ? DistMax : t[DistW-1:0];
        end
        return r;
    endfunction

    // Track register writes, predict on each input transaction, compare outputs.
    always @(posedge i_clk) begin
        t_hit want, got;
        if (!i_rst_n) begin
            sph_cx  <= '0;
            sph_cy  <= '0;
            sph_cz  <= '0;
            sph_rad <= RadW'(65536);
            expected_hits.delete();
            o_fail_count   <= 0;
            o_pending      <= 0;
            o_results_seen <= 0;
            o_hits_seen    <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    RegCx:  sph_cx  <= pwdata;
                    RegCy:  sph_cy  <= pwdata;
                    RegCz:  sph_cz  <= pwdata;
                    RegRad: sph_rad <= pwdata[RadW-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) expected_hits.push_back(trace_ray(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                o_results_seen <= o_results_seen + 1;
                if (got.hit) o_hits_seen <= o_hits_seen + 1;
                if (expected_hits.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result hit=%0b distance=%0d",
                                 $realtime, got.hit, got.distance);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_hits.pop_front();
                    if (want.hit !== got.hit || want.distance !== got.distance) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch expected hit=%0b distance=%0d, got hit=%0b distance=%0d",
                                     $realtime, want.hit, want.distance, got.hit,
                                     got.distance);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_hits.size();
        end
    end

endmodule

@@ tb/ray_sphere_intersect_tb.sv @@
module ray_sphere_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rsi_pkg::*;

    localparam int Unit = 65536;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [31:0]  o_m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count, pending, results_seen, hits_seen;
    int rays_sent = 0;
    int stall_mode = 0;
    logic signed [31:0] cur_cx = 0, cur_cy = 0, cur_cz = 0;

    always #6 i_clk = ~i_clk;

    ray_sphere_intersect dut (.*);

    ray_sphere_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_hits_seen(hits_seen)
    );

    // Result side stalls on its own pattern, in one of four modes redrawn at random.
    always @(posedge i_clk) begin
        int unsigned cyc;
        cyc = cyc + 1;
        if (cyc % 128 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 1) == 0);
            2:       i_m_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_tready <= (cyc % 5 != 0);
        endcase
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_sphere(logic signed [31:0] cx, cy, cz, logic [30:0] rad);
        reg_write(RegCx, cx);
        reg_write(RegCy, cy);
        reg_write(RegCz, cz);
        reg_write(RegRad, {1'b0, rad});
        cur_cx = cx;
        cur_cy = cy;
        cur_cz = cz;
    endtask

    // Holds valid until the block takes the transaction; ready is sampled mid-cycle.
    task automatic send_ray(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz);
        logic took;
        i_s_tdata <= {dz, dy, dx, oz, oy, ox};
        i_s_tvalid <= 1'b1;
        do begin
            @(negedge i_clk);
            took = o_s_tready;
            @(posedge i_clk);
        end while (!took);
        rays_sent++;
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Wait for every expected result, then let the pipeline drain.
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    function automatic logic [15:0] dir_comp(bit major);
        int v;
        if (major) v = 32767 - $urandom_range(0, 3000);
        else v = $urandom_range(0, 12000) - 6000;
        if (major && $urandom_range(0, 1)) v = -v;
        return 16'(v);
    endfunction

    // Mostly rays that start near the sphere with near-unit directions; some raw noise.
    task automatic random_rays(int n);
        int burst;
        logic [31:0] o[3];
        logic [15:0] d[3];
        int axis;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n > 0; k++, n--) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_ray($urandom, $urandom, $urandom,
                             16'($urandom), 16'($urandom), 16'($urandom));
                end else begin
                    axis = $urandom_range(0, 2);
                    for (int a = 0; a < 3; a++) d[a] = dir_comp(a == axis);
                    o[0] = cur_cx + int'($urandom_range(0, 1 << 22)) - (1 << 21);
                    o[1] = cur_cy + int'($urandom_range(0, 1 << 22)) - (1 << 21);
                    o[2] = cur_cz + int'($urandom_range(0, 1 << 22)) - (1 << 21);
                    send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
                end
            end
            gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
        end
        gap(1);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rays against the unit sphere at the origin after reset.
        send_ray(0, 0, -5 * Unit, 0, 0, 32767);          // plain hit
        send_ray(0, 3 * Unit, -5 * Unit, 0, 0, 32767);   // miss
        send_ray(Unit, 0, 5 * Unit, 0, 0, 16'h8000);     // tangent, zero discriminant
        send_ray(0, 0, 5 * Unit, 0, 0, 32767);           // both roots behind
        send_ray(0, 0, 0, 32767, 0, 0);                  // inside the sphere
        send_ray(0, 0, Unit + 65, 0, 0, 16'h8000);       // near root exactly at the limit
        send_ray(0, 0, Unit + 66, 0, 0, 16'h8000);       // near root just past the limit
        send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32767, 32767, 32767);
        send_ray(32'h8000_0000, 0, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 0);
        send_ray(0, 0, -3 * Unit, 0, 0, 0);              // zero direction
        send_ray(0, 0, -3 * Unit, 32767, 32767, 32767);  // non-unit direction
        gap(1);
        random_rays(120);
        drain();

        set_sphere(3 * Unit, -2 * Unit, Unit, 31'(5 * Unit / 2));
        send_ray(3 * Unit, -2 * Unit, -10 * Unit, 0, 0, 32767);
        gap(1);
        random_rays(140);
        drain();

        set_sphere(0, 0, 0, 0);
        send_ray(0, 0, -Unit, 0, 0, 32767);
        gap(1);
        random_rays(120);
        drain();

        // Huge sphere: distances overflow and saturate.
        set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 32767);
        send_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'h8000, 32767, 0);
        gap(1);
        random_rays(140);
        drain();

        set_sphere($urandom_range(0, 1 << 22) - (1 << 21), $urandom_range(0, 1 << 22) - (1 << 21),
                   $urandom_range(0, 1 << 22) - (1 << 21), 31'($urandom_range(Unit, 8 * Unit)));
        random_rays(150);
        drain();

        $display("Traced %0d rays over five sphere settings with random stalls on both sides.",
                 rays_sent);
        $display("Checked %0d results, %0d of them hits.", results_seen, hits_seen);
        if (fail_count == 0) begin
            $display("ray_sphere_intersect regression: pass");
        end else begin
            $display("ray_sphere_intersect regression: fail");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Timed out waiting for results.");
        $display("ray_sphere_intersect regression: fail");
        $finish;
    end

endmodule
